// ===== rtl/pipr_pkg.sv =====
// ----------------------------------------------------------------------------
// pipr_pkg: shared types, widths and helpers for the ray-cast unit
// Coordinate width, orientation codes, queue entry layout and the sign
// helper used by the front part.
// ----------------------------------------------------------------------------
package pipr_pkg;

    // coordinate width and derived widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // queue depth between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // far x after reset: largest positive coordinate
    localparam logic [COORD_W-1:0] RAY_FAR_X_RST = {1'b0, {(COORD_W-1){1'b1}}};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // sign of an orientation determinant
    typedef enum logic [1:0] {
        ORI_ZERO = 2'd0,
        ORI_POS  = 2'd1,
        ORI_NEG  = 2'd2
    } ori_t;

    // one classified edge, as it travels through the queue
    typedef struct packed {
        logic crossed;
        logic bound;
        logic first;
        logic last;
    } pipr_item_t;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } pipr_q_stat_t;

    // sign of (lhs - rhs) without forming the difference
    function automatic ori_t ori_sign(input prod_t lhs, input prod_t rhs);
        ori_t code;
        if (lhs > rhs)
            code = ORI_POS;
        else if (lhs == rhs)
            code = ORI_ZERO;
        else
            code = ORI_NEG;
        return code;
    endfunction

    // point (px,py) inside the bounding box of segment a-b
    function automatic logic in_box(input coord_t px, input coord_t py,
                                    input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by);
        logic x_ok;
        logic y_ok;
        x_ok = ((px >= ax) && (px <= bx)) || ((px >= bx) && (px <= ax));
        y_ok = ((py >= ay) && (py <= by)) || ((py >= by) && (py <= ay));
        return x_ok && y_ok;
    endfunction

endpackage

// ===== rtl/pipr_front.sv =====
// ----------------------------------------------------------------------------
// pipr_front: edge product stage and classifier
// Forms the seven orientation products and four box tests per edge in one
// registered stage, then classifies the edge as crossing or boundary.
// ----------------------------------------------------------------------------
module pipr_front
    import pipr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  coord_t     ray_far_x,
    input  logic       in_valid,
    output logic       in_stall,
    input  coord_t     point_x,
    input  coord_t     point_y,
    input  coord_t     edge_ax,
    input  coord_t     edge_ay,
    input  coord_t     edge_bx,
    input  coord_t     edge_by,
    input  logic       first_edge,
    input  logic       last_edge,
    output logic       push_valid,
    input  logic       push_ready,
    output pipr_item_t push_item
);

    // coordinate differences, sign-extended by one bit
    diff_t d_py_ay, d_bx_px, d_px_ax, d_by_py, d_by_ay, d_px_bx;
    diff_t d_bx_ax, d_py_by, d_fx_bx, d_fx_px, d_ay_py;

    // products for the orientation tests
    prod_t m0_next, m1_next, m2_next, m3_next, m4_next, m5_next, m6_next;
    prod_t m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;

    // box tests: P in AB, Q in AB, A in PQ, B in PQ
    logic box_p_reg, box_q_reg, box_a_reg, box_b_reg;
    logic first_reg, last_reg;
    logic s1_valid_reg, s1_valid_next;
    logic s1_load;

    ori_t ob, o1, o2, o3, o4;

    assign d_py_ay = {point_y[COORD_W-1], point_y} - {edge_ay[COORD_W-1], edge_ay};
    assign d_bx_px = {edge_bx[COORD_W-1], edge_bx} - {point_x[COORD_W-1], point_x};
    assign d_px_ax = {point_x[COORD_W-1], point_x} - {edge_ax[COORD_W-1], edge_ax};
    assign d_by_py = {edge_by[COORD_W-1], edge_by} - {point_y[COORD_W-1], point_y};
    assign d_by_ay = {edge_by[COORD_W-1], edge_by} - {edge_ay[COORD_W-1], edge_ay};
    assign d_px_bx = {point_x[COORD_W-1], point_x} - {edge_bx[COORD_W-1], edge_bx};
    assign d_bx_ax = {edge_bx[COORD_W-1], edge_bx} - {edge_ax[COORD_W-1], edge_ax};
    assign d_py_by = {point_y[COORD_W-1], point_y} - {edge_by[COORD_W-1], edge_by};
    assign d_fx_bx = {ray_far_x[COORD_W-1], ray_far_x} - {edge_bx[COORD_W-1], edge_bx};
    assign d_fx_px = {ray_far_x[COORD_W-1], ray_far_x} - {point_x[COORD_W-1], point_x};
    assign d_ay_py = {edge_ay[COORD_W-1], edge_ay} - {point_y[COORD_W-1], point_y};

    // boundary test orient(A,P,B), crossing tests o1..o4
    assign m0_next = d_py_ay * d_bx_px;
    assign m1_next = d_px_ax * d_by_py;
    assign m2_next = d_by_ay * d_px_bx;
    assign m3_next = d_bx_ax * d_py_by;
    assign m4_next = d_by_ay * d_fx_bx;
    assign m5_next = d_fx_px * d_ay_py;
    assign m6_next = d_fx_px * d_by_py;

    // stage handshake
    assign s1_load  = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !push_ready;

    always_comb
    begin
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // product and box registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            m0_reg    <= m0_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            m3_reg    <= m3_next;
            m4_reg    <= m4_next;
            m5_reg    <= m5_next;
            m6_reg    <= m6_next;
            box_p_reg <= in_box(point_x, point_y, edge_ax, edge_ay, edge_bx, edge_by);
            box_q_reg <= in_box(ray_far_x, point_y, edge_ax, edge_ay, edge_bx, edge_by);
            box_a_reg <= in_box(edge_ax, edge_ay, point_x, point_y, ray_far_x, point_y);
            box_b_reg <= in_box(edge_bx, edge_by, point_x, point_y, ray_far_x, point_y);
            first_reg <= first_edge;
            last_reg  <= last_edge;
        end
    end

    // orientation signs; o3 and o4 reduce to the sign of a negated product
    assign ob = ori_sign(m0_reg, m1_reg);
    assign o1 = ori_sign(m2_reg, m3_reg);
    assign o2 = ori_sign(m4_reg, m3_reg);
    assign o3 = ori_sign('0, m5_reg);
    assign o4 = ori_sign('0, m6_reg);

    // classification
    always_comb
    begin
        push_item.bound   = (ob == ORI_ZERO) && box_p_reg;
        push_item.crossed = ((o1 != o2) && (o3 != o4))
                         || ((o1 == ORI_ZERO) && box_p_reg)
                         || ((o2 == ORI_ZERO) && box_q_reg)
                         || ((o3 == ORI_ZERO) && box_a_reg)
                         || ((o4 == ORI_ZERO) && box_b_reg);
        push_item.first   = first_reg;
        push_item.last    = last_reg;
    end

    assign push_valid = s1_valid_reg;

endmodule

// ===== rtl/pipr_fifo.sv =====
// ----------------------------------------------------------------------------
// pipr_fifo: short queue of classified edges
// Flip-flop queue between the front and back parts; push blocked when full.
// ----------------------------------------------------------------------------
module pipr_fifo
    import pipr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  pipr_item_t   push_item,
    output logic         pop_valid,
    input  logic         pop_ready,
    output pipr_item_t   pop_item,
    output pipr_q_stat_t stat
);

    pipr_item_t mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic push_fire, pop_fire;

    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    assign push_fire = push_valid && push_ready;
    assign pop_fire  = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push_fire ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_fire && !pop_fire)
            cnt_next = Q_CNT_W'(cnt_reg + 1'b1);
        else if (pop_fire && !push_fire)
            cnt_next = Q_CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/pipr_back.sv =====
// ----------------------------------------------------------------------------
// pipr_back: parity and boundary accumulation with result register
// Folds each classified edge into the polygon accumulators and registers
// the result on the last edge.
// ----------------------------------------------------------------------------
module pipr_back
    import pipr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  pipr_item_t pop_item,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       inside_res,
    output logic       on_boundary
);

    logic parity_reg, parity_next;
    logic bound_reg, bound_next;
    logic out_valid_reg, out_valid_next;
    logic inside_reg, inside_next;
    logic onb_reg, onb_next;
    logic par_base, bnd_base, par_new, bnd_new;
    logic pop_fire;

    // a last edge needs room in the result register
    assign pop_ready = !pop_item.last || !out_valid_reg || !out_stall;
    assign pop_fire  = pop_valid && pop_ready;

    // accumulator update
    always_comb
    begin
        par_base = pop_item.first ? 1'b0 : parity_reg;
        bnd_base = pop_item.first ? 1'b0 : bound_reg;
        if (pop_item.bound)
        begin
            bnd_new = 1'b1;
            par_new = par_base;
        end
        else
        begin
            bnd_new = bnd_base;
            par_new = par_base ^ pop_item.crossed;
        end

        parity_next    = parity_reg;
        bound_next     = bound_reg;
        out_valid_next = out_valid_reg && out_stall;
        inside_next    = inside_reg;
        onb_next       = onb_reg;
        if (pop_fire)
        begin
            if (pop_item.last)
            begin
                parity_next    = 1'b0;
                bound_next     = 1'b0;
                out_valid_next = 1'b1;
                inside_next    = par_new | bnd_new;
                onb_next       = bnd_new;
            end
            else
            begin
                parity_next = par_new;
                bound_next  = bnd_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            bound_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            parity_reg    <= parity_next;
            bound_reg     <= bound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        onb_reg    <= onb_next;
    end

    assign out_valid   = out_valid_reg;
    assign inside_res  = inside_reg;
    assign on_boundary = onb_reg;

endmodule

// ===== rtl/point_in_polygon_ray_cast_unit.sv =====
// Path: a last edge passes the product stage register, then the queue write,
// then the result register, from which its result is shown.
// Throughput: one edge per cycle, set by the single product stage and the
// one-entry-per-cycle queue; a held result stops only the next last edge, and
// edges behind it back up into the input once the queue and stage are full.
// Reset: accumulators and queue cleared, ray_far_x set to its largest value.
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_unit: ray-casting point-in-polygon test
// One polygon edge per transfer; a result is produced on each last edge.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast_unit
    import pipr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  coord_t cfg_data,
    input  logic   in_valid,
    output logic   in_stall,
    input  coord_t point_x,
    input  coord_t point_y,
    input  coord_t edge_ax,
    input  coord_t edge_ay,
    input  coord_t edge_bx,
    input  coord_t edge_by,
    input  logic   first_edge,
    input  logic   last_edge,
    output logic   out_valid,
    input  logic   out_stall,
    output logic   inside_res,
    output logic   on_boundary
);

    coord_t       ray_far_x_reg, ray_far_x_next;
    logic         push_valid, push_ready;
    pipr_item_t   push_item;
    logic         pop_valid, pop_ready;
    pipr_item_t   pop_item;
    pipr_q_stat_t q_stat;

    // far-x register
    assign cfg_ready      = 1'b1;
    assign ray_far_x_next = (cfg_valid && cfg_ready) ? cfg_data : ray_far_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_far_x_reg <= RAY_FAR_X_RST;
        else
            ray_far_x_reg <= ray_far_x_next;
    end

    pipr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ray_far_x  (ray_far_x_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .edge_ax    (edge_ax),
        .edge_ay    (edge_ay),
        .edge_bx    (edge_bx),
        .edge_by    (edge_by),
        .first_edge (first_edge),
        .last_edge  (last_edge),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    pipr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .stat       (q_stat)
    );

    pipr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res),
        .on_boundary (on_boundary)
    );

    // a new result only follows a last edge leaving the queue
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop_valid && pop_ready && pop_item.last))
        else $error("result without a last edge");

    // a push without a pop leaves the queue non-empty
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && !(pop_valid && pop_ready)) |=> !q_stat.empty)
        else $error("queue lost an entry");

    // boundary result always reports inside
    a_boundary_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && on_boundary) |-> inside_res)
        else $error("boundary point reported outside");

    // configuration transfer lands in the far-x register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (ray_far_x_reg == $past(cfg_data)))
        else $error("far-x write lost");

endmodule
